// ===== hw/rtl/hws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hws_pkg;

  // defaults for the top-level parameters
  localparam int MAX_WINDOW_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 32;

  // fixed field widths on the stream ports
  localparam int FIELD_W = 32;
  localparam int WLEN_W  = 5;

  // configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_INCLUDE_CURRENT = CFG_INDEX_W'(1);

endpackage

`default_nettype wire

// ===== hw/rtl/history_window_stacker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// history window stacker: keeps a ring of the last window_length samples and,
// for every input sample, streams the whole window out, oldest to newest.
//
// channels
//   s_axis  : one input transaction carries a sample (tdata) and a restart flag
//             (tuser); restart marks the ring as empty before the sample is used
//   m_axis  : window_length output transactions per input, tlast on the newest
//   cfg     : register writes, index 0 window_length, index 1 include_current;
//             always ready, write only while the block is idle
//
// sequence, with L the effective window length (1..MAX_WINDOW)
//   the history lives in one single-port synchronous memory, so each sample
//   takes an accept step, a store step and L read steps, one after another
//   the first sample after reset or restart adds a fill sweep that
//   copies it into every slot in use before the store and the reads
//   the store comes before the reads (include_current, store first) or after
//   them (store after); the first result is registered in the first read step
//
// reset clears the control state and the per-slot valid flags, so every slot
// reads as zero until written; no clearing pass is needed
// a stalled receiver holds the output register and halts the read sequence;
// the input side stays not-ready until the window has been read out
module history_window_stacker
  import hws_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [FIELD_W-1:0]     s_axis_tdata,   // [31:0] sample
  input  wire logic [0:0]             s_axis_tuser,   // [0] restart

  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output      logic [FIELD_W-1:0]     m_axis_tdata,   // [31:0] history_value
  output      logic                   m_axis_tlast,   // window_last

  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  // sequencer states
  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_IDLE  = 2'd0;  // waiting for a sample
  localparam logic [ST_W-1:0] ST_FILL  = 2'd1;  // copy the first sample into all slots
  localparam logic [ST_W-1:0] ST_STORE = 2'd2;  // write the sample at the ring position
  localparam logic [ST_W-1:0] ST_EMIT  = 2'd3;  // read the window out

  // configuration registers
  logic [WLEN_W-1:0] wlen_q;
  logic              incl_cfg_q;

  // history memory, no reset; valid flags make unwritten slots read as zero
  logic [SAMPLE_BITS-1:0] slot_mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  ent_valid_q, ent_valid_d;

  // sequencer
  logic [ST_W-1:0]        state_q, state_d;
  logic [IDX_W-1:0]       cnt_q, cnt_d;        // fill slot or result number
  logic [IDX_W-1:0]       rd_idx_q, rd_idx_d;  // ring slot being read
  logic [IDX_W-1:0]       wp_q, wp_d;          // ring write position
  logic                   filled_q, filled_d;
  logic [IDX_W-1:0]       len_m1_q, len_m1_d;  // window length minus one, per item
  logic                   incl_q, incl_d;
  logic [SAMPLE_BITS-1:0] sample_q;

  // output register
  logic                   m_tvalid_q, m_tvalid_d;
  logic                   m_tlast_q, m_tlast_d;
  logic                   out_ok_q, out_ok_d;  // slot had been written
  logic [SAMPLE_BITS-1:0] out_data_q;

  logic                   s_accept;
  logic                   out_free;
  logic                   mem_we;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_waddr;
  logic [IDX_W-1:0]       len_m1_cfg;
  logic [IDX_W-1:0]       wp_start;
  logic [IDX_W-1:0]       wp_next;
  logic [IDX_W-1:0]       rd_next;
  logic [SAMPLE_BITS+FIELD_W-1:0] in_wide;
  logic [SAMPLE_BITS+FIELD_W-1:0] out_wide;

  // sample narrowed or zero-extended to the stored width
  assign in_wide  = {{SAMPLE_BITS{1'b0}}, s_axis_tdata};
  assign out_wide = {{FIELD_W{1'b0}}, out_data_q & {SAMPLE_BITS{out_ok_q}}};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tlast  = m_tlast_q;
  assign m_axis_tdata  = out_wide[FIELD_W-1:0];

  // effective window length: zero acts as one, large values saturate
  always_comb begin
    if (wlen_q == '0) begin
      len_m1_cfg = '0;
    end else if (32'(wlen_q) > MAX_WINDOW) begin
      len_m1_cfg = IDX_W'(MAX_WINDOW - 1);
    end else begin
      len_m1_cfg = IDX_W'(wlen_q - 5'd1);
    end
  end

  // a restart, or a position left beyond a shortened window, starts at slot zero
  assign wp_start = (s_axis_tuser[0] || (wp_q > len_m1_cfg)) ? '0 : wp_q;
  assign wp_next  = (wp_q == len_m1_q) ? '0 : wp_q + 1'b1;
  assign rd_next  = (rd_idx_q == len_m1_q) ? '0 : rd_idx_q + 1'b1;
  assign out_free = !m_tvalid_q || m_axis_tready;
  assign mem_waddr = (state_q == ST_FILL) ? cnt_q : wp_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    wp_d        = wp_q;
    filled_d    = filled_q;
    len_m1_d    = len_m1_q;
    incl_d      = incl_q;
    ent_valid_d = ent_valid_q;
    m_tvalid_d  = m_tvalid_q;
    m_tlast_d   = m_tlast_q;
    out_ok_d    = out_ok_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    // output transaction frees the register
    if (m_tvalid_q && m_axis_tready) begin
      m_tvalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          len_m1_d = len_m1_cfg;
          incl_d   = incl_cfg_q;
          wp_d     = wp_start;
          rd_idx_d = wp_start;
          cnt_d    = '0;
          if (s_axis_tuser[0] || !filled_q) begin
            filled_d = 1'b0;
            state_d  = ST_FILL;
          end else if (incl_cfg_q) begin
            state_d = ST_STORE;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        ent_valid_d[cnt_q] = 1'b1;
        if (cnt_q == len_m1_q) begin
          filled_d = 1'b1;
          cnt_d    = '0;
          state_d  = incl_q ? ST_STORE : ST_EMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_STORE: begin
        mem_we = 1'b1;
        ent_valid_d[wp_q] = 1'b1;
        wp_d = wp_next;
        if (incl_q) begin
          // window starts at the oldest slot, just past the new sample
          rd_idx_d = wp_next;
          cnt_d    = '0;
          state_d  = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          mem_re     = 1'b1;
          m_tvalid_d = 1'b1;
          m_tlast_d  = (cnt_q == len_m1_q);
          out_ok_d   = ent_valid_q[rd_idx_q];
          if (cnt_q == len_m1_q) begin
            // store-after mode writes the sample once the window is out
            state_d = incl_q ? ST_IDLE : ST_STORE;
          end else begin
            cnt_d    = cnt_q + 1'b1;
            rd_idx_d = rd_next;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      wp_q        <= '0;
      filled_q    <= 1'b0;
      len_m1_q    <= '0;
      incl_q      <= 1'b1;
      ent_valid_q <= '0;
      m_tvalid_q  <= 1'b0;
      m_tlast_q   <= 1'b0;
      out_ok_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      wp_q        <= wp_d;
      filled_q    <= filled_d;
      len_m1_q    <= len_m1_d;
      incl_q      <= incl_d;
      ent_valid_q <= ent_valid_d;
      m_tvalid_q  <= m_tvalid_d;
      m_tlast_q   <= m_tlast_d;
      out_ok_q    <= out_ok_d;
    end
  end

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q     <= WLEN_W'(1);
      incl_cfg_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WINDOW_LENGTH:   wlen_q     <= cfg_data_i[WLEN_W-1:0];
        REG_INCLUDE_CURRENT: incl_cfg_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sample holding register
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      sample_q <= in_wide[SAMPLE_BITS-1:0];
    end
  end

  // history memory, read data lands straight in the output register
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= sample_q;
    end
    if (mem_re) begin
      out_data_q <= slot_mem[rd_idx_q];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hws_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hws_checker
  import hws_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               s_axis_tvalid,
  input wire logic               s_axis_tready,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [FIELD_W-1:0] m_axis_tdata,
  input wire logic               m_axis_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

  // an accepted sample keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a sample transaction");

  // no new sample while a window is only partly out
  a_no_accept_mid_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(m_axis_tvalid && !m_axis_tlast))
    else $error("input ready during a window");

  // a non-final result transaction is followed straight by the next result
  a_next_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a window");

endmodule

bind history_window_stacker hws_checker u_hws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== test/tb_history_window_stacker.sv =====
`timescale 1ns / 1ps

// checks history_window_stacker against its own predictor of the sample ring:
// every input transaction queues the window it should produce, and each output
// transaction is compared with the oldest queued entry
module tb_history_window_stacker;
  import hws_pkg::*;

  localparam int WINDOW_SLOTS = MAX_WINDOW_DEF;

  // one expected output transaction
  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               last;
  } window_beat_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;

  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [FIELD_W-1:0]     s_axis_tdata;   // [31:0] sample
  logic [0:0]             s_axis_tuser;   // [0] restart

  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [FIELD_W-1:0]     m_axis_tdata;   // [31:0] history_value
  logic                   m_axis_tlast;

  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  // predicted contents of the history ring and the register copies
  logic [FIELD_W-1:0] hist_slots [WINDOW_SLOTS];
  int                 hist_wpos;
  logic               hist_filled;
  logic [WLEN_W-1:0]  cfg_wlen;
  logic               cfg_incl;

  window_beat_t pending_windows[$];
  int           mismatches;

  // random idling on both sides while set
  logic idling_on;

  // long receiver hold-off, requested by toggling rx_hold_go
  logic rx_hold_go;
  int   rx_hold_len;

  always #2 clk_i = ~clk_i;

  history_window_stacker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // zero counts as one slot, anything above the ring size saturates
  function automatic int window_slots_used();
    if (cfg_wlen == '0) begin
      return 1;
    end
    if (int'(cfg_wlen) > WINDOW_SLOTS) begin
      return WINDOW_SLOTS;
    end
    return int'(cfg_wlen);
  endfunction

  task automatic store_slot(input logic [FIELD_W-1:0] smp, input int len);
    hist_slots[hist_wpos] = smp;
    hist_wpos = (hist_wpos + 1) % len;
  endtask

  // oldest slot sits at the write position, newest just below it
  task automatic queue_window(input int len);
    window_beat_t beat;
    for (int i = 0; i < len; i++) begin
      beat.value = hist_slots[(hist_wpos + i) % len];
      beat.last  = (i == len - 1);
      pending_windows = {pending_windows, beat};
    end
  endtask

  task automatic predict_window(input logic [FIELD_W-1:0] smp, input logic restart);
    int len;
    len = window_slots_used();
    if (restart) begin
      hist_filled = 1'b0;
      hist_wpos   = 0;
    end
    // ring shrunk under a running write position
    if (hist_wpos >= len) begin
      hist_wpos = 0;
    end
    // first sample of a run fills every slot in use, the rest keep old data
    if (!hist_filled) begin
      for (int i = 0; i < len; i++) begin
        hist_slots[i] = smp;
      end
      hist_filled = 1'b1;
    end
    if (cfg_incl) begin
      store_slot(smp, len);
      queue_window(len);
    end else begin
      queue_window(len);
      store_slot(smp, len);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checker: one compare per output transaction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    window_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_windows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected output value %h last %b", $realtime,
                   m_axis_tdata, m_axis_tlast);
        end
      end else begin
        want = pending_windows.pop_front();
        if (m_axis_tdata !== want.value || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected value %h last %b, got value %h last %b",
                     $realtime, want.value, want.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, plus the long hold-off on request
  // ---------------------------------------------------------------------------

  logic rx_hold_seen = 1'b0;
  int   rx_hold_left = 0;
  int   rx_stall_left = 0;

  always @(posedge clk_i) begin
    if (rx_hold_go != rx_hold_seen) begin
      rx_hold_seen = rx_hold_go;
      rx_hold_left = rx_hold_len;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left--;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left = $urandom_range(1, 6) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // shared drivers
  // ---------------------------------------------------------------------------

  // offers one sample, possibly after a gap, and returns in the step of the
  // transaction; tvalid stays high so back-to-back samples need no toggle
  task automatic send_sample(input logic [FIELD_W-1:0] smp, input logic restart);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_window(smp, restart);
  endtask

  // register writes only once every window is out and the block has settled
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    s_axis_tvalid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_WINDOW_LENGTH:   cfg_wlen = data[WLEN_W-1:0];
      REG_INCLUDE_CURRENT: cfg_incl = data[0];
      default: ;
    endcase
  endtask

  // upper data bits are noise the block must not look at
  task automatic set_window_length(input logic [WLEN_W-1:0] wlen);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom;
    data[WLEN_W-1:0] = wlen;
    write_reg(REG_WINDOW_LENGTH, data);
  endtask

  task automatic set_include_current(input logic incl);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom;
    data[0] = incl;
    write_reg(REG_INCLUDE_CURRENT, data);
  endtask

  function automatic logic [FIELD_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly short windows keep the run fast, with the odd extreme
  function automatic logic [WLEN_W-1:0] random_window_length();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return WLEN_W'($urandom_range(1, 6));
    if (pick < 17) return WLEN_W'($urandom_range(7, 15));
    if (pick == 17) return WLEN_W'(WINDOW_SLOTS);
    if (pick == 18) return '0;
    return WLEN_W'($urandom_range(17, 31));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // defaults out of reset: one slot, store first; restart with no history
  task automatic test_reset_state();
    send_sample('1, 1'b1);
    send_sample('0, 1'b0);
  endtask

  // full ring with lagging output, then zero and oversized lengths
  task automatic test_length_extremes();
    set_window_length(WLEN_W'(WINDOW_SLOTS));
    set_include_current(1'b0);
    send_sample($urandom, 1'b1);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample($urandom, 1'b1);
    set_window_length('0);
    send_sample($urandom, 1'b0);
    send_sample($urandom, 1'b0);
    set_window_length('1);
    send_sample($urandom, 1'b0);
    send_sample($urandom, 1'b0);
    set_window_length(WLEN_W'(WINDOW_SLOTS + 1));
    send_sample($urandom, 1'b0);
  endtask

  // shrink below the write position, then grow over slots left from before
  task automatic test_length_changes();
    set_window_length(WLEN_W'(8));
    set_include_current(1'b1);
    send_sample($urandom, 1'b1);
    repeat (5) send_sample($urandom, 1'b0);
    set_window_length(WLEN_W'(3));
    repeat (2) send_sample($urandom, 1'b0);
    set_window_length(WLEN_W'(12));
    repeat (2) send_sample($urandom, 1'b0);
  endtask

  // writes to unused indexes must leave both registers alone
  task automatic test_unknown_register();
    logic [CFG_DATA_W-1:0] data;
    data = $urandom;
    data[WLEN_W-1:0] = '0;
    write_reg(CFG_INDEX_W'(2), data);
    write_reg('1, data);
    write_reg(CFG_INDEX_W'($urandom_range(3, 14)), $urandom);
    repeat (2) send_sample($urandom, 1'b0);
  endtask

  // receiver holds off long enough that the input side has to stall
  task automatic test_backpressure();
    set_window_length(WLEN_W'(WINDOW_SLOTS));
    set_include_current(1'b1);
    rx_hold_len = 300;
    rx_hold_go  = ~rx_hold_go;
    send_sample($urandom, 1'b1);
    repeat (5) send_sample(random_sample(), 1'b0);
  endtask

  // random settings between bursts of samples, rare restarts
  task automatic test_random_traffic(input int n_items);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      idling_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) != 0) begin
        set_window_length(random_window_length());
      end
      if ($urandom_range(0, 2) == 0) begin
        set_include_current(1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 9) == 0) begin
        write_reg(CFG_INDEX_W'($urandom_range(2, 15)), $urandom);
      end
      burst = $urandom_range(8, 30);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        send_sample(random_sample(), $urandom_range(0, 11) == 0);
        sent++;
      end
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_streaming_no_idle(input int n_items);
    idling_on = 1'b0;
    set_window_length(WLEN_W'($urandom_range(1, 4)));
    set_include_current(1'($urandom_range(0, 1)));
    for (int i = 0; i < n_items; i++) begin
      send_sample(random_sample(), $urandom_range(0, 15) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    idling_on     = 1'b1;
    rx_hold_go    = 1'b0;
    rx_hold_len   = 0;
    mismatches    = 0;
    // register and ring state as left by reset
    cfg_wlen      = WLEN_W'(1);
    cfg_incl      = 1'b1;
    hist_wpos     = 0;
    hist_filled   = 1'b0;
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      hist_slots[i] = '0;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_length_extremes();
    test_length_changes();
    test_unknown_register();
    test_backpressure();
    test_random_traffic(260);
    test_streaming_no_idle(30);

    s_axis_tvalid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== history_window_stacker.f =====
hw/rtl/hws_pkg.sv
hw/rtl/history_window_stacker.sv
hw/rtl/hws_checker.sv
test/tb_history_window_stacker.sv
